// File: hdl/conductivity_range_temp_compensate_defines.svh
// Assertion helpers used by the checked module crtc_ctrl.
`ifndef CONDUCTIVITY_RANGE_TEMP_COMPENSATE_DEFINES_SVH
`define CONDUCTIVITY_RANGE_TEMP_COMPENSATE_DEFINES_SVH

// Same-cycle implication, idle during reset.
`define CRTC_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, idle during reset.
`define CRTC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hdl/crtc_pkg.sv
package crtc_pkg;

   // Field widths
   localparam int OP_W   = 2;
   localparam int MV_W   = 13;
   localparam int TEMP_W = 12;
   localparam int K_W    = 15;
   localparam int COND_W = 17;
   localparam int STAT_W = 2;
   localparam int USCM_W = 24;

   // Datapath widths
   localparam int FRAC_W  = 16;
   localparam int RAW_W   = 21;
   localparam int D_W     = 20;
   localparam int K_FRAC  = 14;
   localparam int RK_W    = 36;
   localparam int VAL_W   = RK_W - K_FRAC;
   localparam int R625_W  = 31;
   localparam int STD_W   = 14;
   localparam int SD_W    = 33;
   localparam int NUM_W   = 46;
   localparam int DEN_W   = 25;
   localparam int Q_W     = 17;

   // Shifts that fold the fixed-point scale factors into the divider operands
   localparam int CAL_SHIFT = 7;
   localparam int RND_SHIFT = 5;
   localparam int DEN_SHIFT = 6;

   localparam logic [OP_W-1:0] OP_MEASURE   = 2'd0;
   localparam logic [OP_W-1:0] OP_CALIBRATE = 2'd1;
   localparam logic [OP_W-1:0] OP_LOAD      = 2'd2;

   localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
   localparam logic [STAT_W-1:0] ST_WINDOW = 2'd1;
   localparam logic [STAT_W-1:0] ST_BOUND  = 2'd2;

   localparam logic [USCM_W-1:0] USCM_RESET = 24'd399610;
   localparam logic [K_W-1:0]    K_ONE      = 15'd16384;
   localparam logic [COND_W-1:0] COND_MAX   = 17'd131071;

   localparam int TF_SCALE   = 160000;
   localparam int TF_SLOPE   = 185;
   localparam int T_REF      = 400;
   localparam int COND_SCALE = 625;

   localparam logic [VAL_W-1:0] VAL_HIGH = 22'd2500;
   localparam logic [VAL_W-1:0] VAL_LOW  = 22'd2000;

   localparam logic [RAW_W-1:0] LOW_WIN_MIN  = 21'd900;
   localparam logic [RAW_W-1:0] LOW_WIN_MAX  = 21'd1900;
   localparam logic [RAW_W-1:0] HIGH_WIN_MIN = 21'd9000;
   localparam logic [RAW_W-1:0] HIGH_WIN_MAX = 21'd16800;

   localparam logic [STD_W-1:0] STD_LOW  = 14'd1413;
   localparam logic [STD_W-1:0] STD_HIGH = 14'd12880;

   localparam logic [Q_W-1:0] K_MIN = 17'd8192;
   localparam logic [Q_W-1:0] K_MAX = 17'd24576;

   typedef struct packed {
      logic latch;
      logic raw;
      logic prep;
      logic sel;
      logic finish;
   } crtc_cmd_type;

   typedef struct packed {
      logic div_done;
      logic out_free;
   } crtc_sts_type;

endpackage

// File: hdl/crtc_if.sv
interface crtc_req_if;
   import crtc_pkg::*;

   logic                     valid;
   logic                     ready;
   logic [OP_W-1:0]          op;
   logic [MV_W-1:0]          voltage_mv;
   logic signed [TEMP_W-1:0] temperature;
   logic [K_W-1:0]           k_low_in;
   logic [K_W-1:0]           k_high_in;

   modport source (output valid, op, voltage_mv, temperature, k_low_in, k_high_in,
                   input ready);
   modport sink   (input valid, op, voltage_mv, temperature, k_low_in, k_high_in,
                   output ready);
endinterface

interface crtc_rsp_if;
   import crtc_pkg::*;

   logic              valid;
   logic              ready;
   logic [COND_W-1:0] conductivity;
   logic [STAT_W-1:0] status;
   logic              high_range;
   logic [K_W-1:0]    k_low_out;
   logic [K_W-1:0]    k_high_out;

   modport source (output valid, conductivity, status, high_range, k_low_out, k_high_out,
                   input ready);
   modport sink   (input valid, conductivity, status, high_range, k_low_out, k_high_out,
                   output ready);
endinterface

// File: hdl/conductivity_range_temp_compensate.sv
// Channel  Ports        Direction  Carries
// -------  -----------  ---------  -----------------------------------------------
// req      req_chan.*   in         op, voltage_mv, temperature, k_low_in, k_high_in
// rsp      rsp_chan.*   out        conductivity, status, high_range, k_low/high_out
// csr      csr_wr_*     in         uscm_per_mv write, no read-back
//
// One word in flight: a new word is accepted only after the current one is finished.
// The 17-step restoring divider runs an overflow check first, then its quotient steps.
// A finished word waits in the output register while the next word is accepted; it is
// only finished once that register is free. Reset is synchronous, active high, and
// restores uscm_per_mv to 399610 and all cell constants to 1.0 in the low range.
module conductivity_range_temp_compensate (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_wr_en,
   input  logic [crtc_pkg::USCM_W-1:0] csr_wr_data,
   crtc_req_if.sink                    req_chan,
   crtc_rsp_if.source                  rsp_chan
);
   import crtc_pkg::*;

   crtc_cmd_type cmd;
   crtc_sts_type sts;

   crtc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   crtc_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .sts         (sts),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .in_op       (req_chan.op),
      .in_mv       (req_chan.voltage_mv),
      .in_temp     (req_chan.temperature),
      .in_klo      (req_chan.k_low_in),
      .in_khi      (req_chan.k_high_in),
      .out_ready   (rsp_chan.ready),
      .out_valid   (rsp_chan.valid),
      .out_cond    (rsp_chan.conductivity),
      .out_status  (rsp_chan.status),
      .out_high    (rsp_chan.high_range),
      .out_klo     (rsp_chan.k_low_out),
      .out_khi     (rsp_chan.k_high_out)
   );

endmodule

// File: hdl/crtc_div.sv
module crtc_div (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [crtc_pkg::NUM_W-1:0] num,
   input  logic [crtc_pkg::DEN_W-1:0] den,
   output logic [crtc_pkg::Q_W-1:0]   quot,
   output logic                      ovf,
   output logic                      done
);
   import crtc_pkg::*;

   localparam int CNT_W = $clog2(Q_W);

   logic [NUM_W-1:0] num_ff;
   logic [DEN_W-1:0] den_ff;
   logic [DEN_W-1:0] rem_ff;
   logic [DEN_W-1:0] rem_in;
   logic [Q_W-1:0]   q_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             busy_ff;
   logic             chk_ff;
   logic             ovf_ff;
   logic             done_ff;
   logic [DEN_W:0]   cand;
   logic [DEN_W:0]   diff;
   logic             ge;

   // One quotient bit per cycle, restoring
   always_comb begin
      cand   = {rem_ff, num_ff[Q_W-1]};
      ge     = cand >= {1'b0, den_ff};
      diff   = cand - {1'b0, den_ff};
      rem_in = ge ? diff[DEN_W-1:0] : cand[DEN_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         chk_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            chk_ff  <= 1'b1;
         end else if (busy_ff && chk_ff) begin
            chk_ff <= 1'b0;
            cnt_ff <= CNT_W'(Q_W - 1);
         end else if (busy_ff) begin
            if (cnt_ff == '0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end else begin
               cnt_ff <= cnt_ff - 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         num_ff <= num;
         den_ff <= den;
      end else if (busy_ff && chk_ff) begin
         // quotient fits Q_W bits only below den * 2^Q_W
         ovf_ff <= num_ff >= NUM_W'({den_ff, {Q_W{1'b0}}});
         rem_ff <= num_ff[Q_W+DEN_W-1:Q_W];
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         q_ff   <= {q_ff[Q_W-2:0], ge};
         num_ff <= {num_ff[NUM_W-2:0], 1'b0};
      end
   end

   assign quot = q_ff;
   assign ovf  = ovf_ff;
   assign done = done_ff;

endmodule

// File: hdl/crtc_dp.sv
module crtc_dp (
   input  logic                            clock,
   input  logic                            reset,
   input  crtc_pkg::crtc_cmd_type          cmd,
   output crtc_pkg::crtc_sts_type          sts,
   input  logic                            csr_wr_en,
   input  logic [crtc_pkg::USCM_W-1:0]     csr_wr_data,
   input  logic [crtc_pkg::OP_W-1:0]       in_op,
   input  logic [crtc_pkg::MV_W-1:0]       in_mv,
   input  logic signed [crtc_pkg::TEMP_W-1:0] in_temp,
   input  logic [crtc_pkg::K_W-1:0]        in_klo,
   input  logic [crtc_pkg::K_W-1:0]        in_khi,
   input  logic                            out_ready,
   output logic                            out_valid,
   output logic [crtc_pkg::COND_W-1:0]     out_cond,
   output logic [crtc_pkg::STAT_W-1:0]     out_status,
   output logic                            out_high,
   output logic [crtc_pkg::K_W-1:0]        out_klo,
   output logic [crtc_pkg::K_W-1:0]        out_khi
);
   import crtc_pkg::*;

   logic [USCM_W-1:0]        uscm_ff;
   logic [K_W-1:0]           active_k_ff;
   logic [K_W-1:0]           active_k_in;
   logic [K_W-1:0]           low_k_ff;
   logic [K_W-1:0]           low_k_in;
   logic [K_W-1:0]           high_k_ff;
   logic [K_W-1:0]           high_k_in;
   logic                     high_sel_ff;
   logic                     high_sel_in;

   logic [OP_W-1:0]          op_ff;
   logic [MV_W-1:0]          mv_ff;
   logic signed [TEMP_W-1:0] temp_ff;
   logic [K_W-1:0]           klo_ff;
   logic [K_W-1:0]           khi_ff;

   logic [MV_W+USCM_W-1:0]   raw_prod;
   logic [RAW_W-1:0]         raw_ff;
   logic [TEMP_W:0]          tdiff;
   logic [D_W-1:0]           tprod;
   logic [D_W-1:0]           d_in;
   logic [D_W-1:0]           d_ff;
   logic                     d_pos;

   logic                     in_low;
   logic                     in_high;
   logic                     in_low_ff;
   logic                     in_high_ff;
   logic [STD_W-1:0]         std_sel;
   logic [RK_W-1:0]          rk_ff;
   logic [R625_W-1:0]        r625_ff;
   logic [SD_W-1:0]          sd_ff;

   logic [VAL_W-1:0]         val;
   logic [NUM_W-1:0]         div_num;
   logic [DEN_W-1:0]         div_den;
   logic [Q_W-1:0]           div_q;
   logic                     div_ovf;
   logic                     div_done;

   logic                     k_ok;
   logic [COND_W-1:0]        cond;
   logic [STAT_W-1:0]        status;

   logic                     out_valid_ff;
   logic [COND_W-1:0]        cond_ff;
   logic [STAT_W-1:0]        status_ff;
   logic                     high_ff;
   logic [K_W-1:0]           klo_out_ff;
   logic [K_W-1:0]           khi_out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         uscm_ff <= USCM_RESET;
      end else if (csr_wr_en) begin
         uscm_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         op_ff   <= in_op;
         mv_ff   <= in_mv;
         temp_ff <= in_temp;
         klo_ff  <= in_klo;
         khi_ff  <= in_khi;
      end
   end

   // Raw conductivity and temperature factor (scaled by 160000)
   always_comb begin
      raw_prod = (MV_W+USCM_W)'(mv_ff) * (MV_W+USCM_W)'(uscm_ff);
      tdiff    = {temp_ff[TEMP_W-1], temp_ff} - (TEMP_W+1)'(T_REF);
      tprod    = {{(D_W-TEMP_W-1){tdiff[TEMP_W]}}, tdiff} * D_W'(TF_SLOPE);
      d_in     = tprod + D_W'(TF_SCALE);
   end

   always_ff @(posedge clock) begin
      if (cmd.raw) begin
         raw_ff <= raw_prod[MV_W+USCM_W-1:FRAC_W];
         d_ff   <= d_in;
      end
   end

   assign d_pos   = !d_ff[D_W-1] && (d_ff != '0);
   assign in_low  = (raw_ff > LOW_WIN_MIN) && (raw_ff < LOW_WIN_MAX);
   assign in_high = (raw_ff > HIGH_WIN_MIN) && (raw_ff < HIGH_WIN_MAX);
   assign std_sel = in_low ? STD_LOW : STD_HIGH;

   always_ff @(posedge clock) begin
      if (cmd.prep) begin
         rk_ff      <= RK_W'(raw_ff) * RK_W'(active_k_ff);
         r625_ff    <= R625_W'(raw_ff) * R625_W'(COND_SCALE);
         sd_ff      <= SD_W'(std_sel) * SD_W'(d_ff[D_W-2:0]);
         in_low_ff  <= in_low;
         in_high_ff <= in_high;
      end
   end

   // Range hysteresis, then the divider operands
   always_comb begin
      val         = rk_ff[RK_W-1:K_FRAC];
      active_k_in = active_k_ff;
      high_sel_in = high_sel_ff;
      if (cmd.sel && op_ff == OP_MEASURE) begin
         if (val > VAL_HIGH) begin
            active_k_in = high_k_ff;
            high_sel_in = 1'b1;
         end else if (val < VAL_LOW) begin
            active_k_in = low_k_ff;
            high_sel_in = 1'b0;
         end
      end
      if (op_ff == OP_CALIBRATE) begin
         // k = (128*std*d + 625*raw) / (1250*raw)
         div_num = NUM_W'({sd_ff, {CAL_SHIFT{1'b0}}}) + NUM_W'(r625_ff);
         div_den = {r625_ff[DEN_W-2:0], 1'b0};
      end else begin
         // cond = (625*raw*k + 32*d) / (64*d)
         div_num = NUM_W'(r625_ff) * NUM_W'(active_k_in)
                 + NUM_W'({d_ff[D_W-2:0], {RND_SHIFT{1'b0}}});
         div_den = {d_ff[D_W-2:0], {DEN_SHIFT{1'b0}}};
      end
   end

   crtc_div u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.sel),
      .num   (div_num),
      .den   (div_den),
      .quot  (div_q),
      .ovf   (div_ovf),
      .done  (div_done)
   );

   always_comb begin
      k_ok      = !div_ovf && (div_q > K_MIN) && (div_q < K_MAX);
      cond      = '0;
      status    = ST_OK;
      low_k_in  = low_k_ff;
      high_k_in = high_k_ff;
      unique case (op_ff)
         OP_MEASURE: begin
            if (d_pos) begin
               cond = div_ovf ? COND_MAX : div_q;
            end
         end
         OP_CALIBRATE: begin
            if (!in_low_ff && !in_high_ff) begin
               status = ST_WINDOW;
            end else if (!d_pos || !k_ok) begin
               status = ST_BOUND;
            end else if (cmd.finish && in_low_ff) begin
               low_k_in = div_q[K_W-1:0];
            end else if (cmd.finish) begin
               high_k_in = div_q[K_W-1:0];
            end
         end
         OP_LOAD: begin
            if (cmd.finish) begin
               low_k_in  = klo_ff;
               high_k_in = khi_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_k_ff <= K_ONE;
         low_k_ff    <= K_ONE;
         high_k_ff   <= K_ONE;
         high_sel_ff <= 1'b0;
      end else begin
         active_k_ff <= active_k_in;
         low_k_ff    <= low_k_in;
         high_k_ff   <= high_k_in;
         high_sel_ff <= high_sel_in;
      end
   end

   // Output word: hold until taken
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.finish) begin
         out_valid_ff <= 1'b1;
      end else if (out_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         cond_ff    <= cond;
         status_ff  <= status;
         high_ff    <= high_sel_ff;
         klo_out_ff <= low_k_in;
         khi_out_ff <= high_k_in;
      end
   end

   assign sts.div_done = div_done;
   assign sts.out_free = !out_valid_ff || out_ready;

   assign out_valid  = out_valid_ff;
   assign out_cond   = cond_ff;
   assign out_status = status_ff;
   assign out_high   = high_ff;
   assign out_klo    = klo_out_ff;
   assign out_khi    = khi_out_ff;

endmodule

// File: hdl/crtc_ctrl.sv
`include "conductivity_range_temp_compensate_defines.svh"

module crtc_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  crtc_pkg::crtc_sts_type sts,
   output crtc_pkg::crtc_cmd_type cmd
);
   import crtc_pkg::*;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_RAW  = 3'd1;
   localparam logic [2:0] S_PREP = 3'd2;
   localparam logic [2:0] S_SEL  = 3'd3;
   localparam logic [2:0] S_DIV  = 3'd4;
   localparam logic [2:0] S_FIN  = 3'd5;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_comb begin
      cmd       = '0;
      state_in  = state_ff;
      req_ready = (state_ff == S_IDLE);
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.latch = 1'b1;
               state_in  = S_RAW;
            end
         end
         S_RAW: begin
            cmd.raw  = 1'b1;
            state_in = S_PREP;
         end
         S_PREP: begin
            cmd.prep = 1'b1;
            state_in = S_SEL;
         end
         S_SEL: begin
            cmd.sel  = 1'b1;
            state_in = S_DIV;
         end
         S_DIV: begin
            if (sts.div_done) begin
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            // wait for room in the output register
            if (sts.out_free) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   `CRTC_ASSERT_IMPL(a_cmd_excl, clock, reset, 1'b1, $onehot0({cmd.latch, cmd.raw, cmd.prep, cmd.sel, cmd.finish}), "datapath commands overlap")
   `CRTC_ASSERT_NEXT(a_div_hold, clock, reset, state_ff == S_DIV && !sts.div_done, state_ff == S_DIV, "left divide wait early")
   `CRTC_ASSERT_IMPL(a_fin_room, clock, reset, cmd.finish, sts.out_free && state_ff == S_FIN, "result written over a waiting word")
   `CRTC_ASSERT_NEXT(a_latch_seq, clock, reset, cmd.latch, state_ff == S_RAW && !req_ready, "accepted word did not start")

endmodule

// File: test/conductivity_range_temp_compensate_tb.sv
`timescale 1ns / 1ps

module conductivity_range_temp_compensate_tb;
   import crtc_pkg::*;

   localparam logic [OP_W-1:0] OP_UNUSED   = 2'd3;
   localparam int              CYCLE_LIMIT = 600000;

   typedef struct packed {
      logic [OP_W-1:0]          op;
      logic [MV_W-1:0]          voltage_mv;
      logic signed [TEMP_W-1:0] temperature;
      logic [K_W-1:0]           k_low_in;
      logic [K_W-1:0]           k_high_in;
   } reading_req_type;

   typedef struct packed {
      logic [COND_W-1:0] conductivity;
      logic [STAT_W-1:0] status;
      logic              high_range;
      logic [K_W-1:0]    k_low_out;
      logic [K_W-1:0]    k_high_out;
   } reading_rsp_type;

   logic              clock;
   logic              reset;
   logic              csr_wr_en;
   logic [USCM_W-1:0] csr_wr_data;

   crtc_req_if req_chan ();
   crtc_rsp_if rsp_chan ();

   conductivity_range_temp_compensate u_top (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan)
   );

   // Shadow copy of the block's state
   logic [USCM_W-1:0] scale_q16 = USCM_RESET;
   logic [K_W-1:0]    act_k     = K_ONE;
   logic [K_W-1:0]    low_k     = K_ONE;
   logic [K_W-1:0]    high_k    = K_ONE;
   logic              high_sel  = 1'b0;

   reading_rsp_type expected_readings[$];

   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int mismatches    = 0;
   int words_sent    = 0;
   int words_checked = 0;
   int scale_writes  = 0;
   int cycle_count   = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_chan.ready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   // Raw conductivity, range hysteresis, temperature compensation, calibration and constant loads
   function automatic reading_rsp_type compensate_word(input reading_req_type w);
      longint unsigned raw, val, num, den, dpos, stdv, kq, cond;
      longint          d;
      int              t;
      bit              in_low, in_high;
      reading_rsp_type r;
      r    = '0;
      cond = 0;
      t    = int'($signed(w.temperature));
      raw  = (longint'(w.voltage_mv) * longint'(scale_q16)) >> FRAC_W;
      d    = longint'(TF_SCALE) + longint'(TF_SLOPE) * longint'(t - T_REF);
      dpos = (d > 0) ? d : 0;
      case (w.op)
         OP_MEASURE: begin
            val = (raw * act_k) >> K_FRAC;
            if (val > VAL_HIGH) begin
               act_k    = high_k;
               high_sel = 1'b1;
            end else if (val < VAL_LOW) begin
               act_k    = low_k;
               high_sel = 1'b0;
            end
            if (d > 0) begin
               num  = raw * act_k * longint'(TF_SCALE);
               den  = longint'(K_ONE) * dpos;
               cond = (num + den / 2) / den;
               if (cond > COND_MAX) cond = 64'(COND_MAX);
            end
         end
         OP_CALIBRATE: begin
            in_low  = raw > LOW_WIN_MIN && raw < LOW_WIN_MAX;
            in_high = raw > HIGH_WIN_MIN && raw < HIGH_WIN_MAX;
            if (!in_low && !in_high) begin
               r.status = ST_WINDOW;
            end else if (d <= 0) begin
               r.status = ST_BOUND;
            end else begin
               stdv = in_low ? 64'(STD_LOW) : 64'(STD_HIGH);
               den  = longint'(TF_SCALE) * raw;
               kq   = (stdv * dpos * longint'(K_ONE) + den / 2) / den;
               if (kq > K_MIN && kq < K_MAX) begin
                  if (in_low) low_k = kq[K_W-1:0];
                  else        high_k = kq[K_W-1:0];
               end else begin
                  r.status = ST_BOUND;
               end
            end
         end
         OP_LOAD: begin
            low_k  = w.k_low_in;
            high_k = w.k_high_in;
         end
         default: ;
      endcase
      r.conductivity = cond[COND_W-1:0];
      r.high_range   = high_sel;
      r.k_low_out    = low_k;
      r.k_high_out   = high_k;
      return r;
   endfunction

   function automatic reading_req_type word(input logic [OP_W-1:0] op, input int mv,
                                            input int t, input int kl, input int kh);
      reading_req_type w;
      w.op          = op;
      w.voltage_mv  = MV_W'(mv);
      w.temperature = TEMP_W'(t);
      w.k_low_in    = K_W'(kl);
      w.k_high_in   = K_W'(kh);
      return w;
   endfunction

   // Smallest voltage whose raw conductivity reaches the target, or a random one if none fits
   function automatic logic [MV_W-1:0] mv_for_raw(input longint unsigned target);
      longint unsigned mv;
      if (scale_q16 == 0) return MV_W'($urandom_range(8191));
      mv = ((target << FRAC_W) + scale_q16 - 1) / scale_q16;
      if (mv > 8191) mv = 64'($urandom_range(8191));
      return mv[MV_W-1:0];
   endfunction

   function automatic reading_req_type random_word();
      reading_req_type w;
      int unsigned     pick;
      pick   = $urandom_range(99);
      w.op   = pick < 45 ? OP_MEASURE : pick < 75 ? OP_CALIBRATE :
               pick < 95 ? OP_LOAD : OP_UNUSED;
      w.k_low_in  = K_W'($urandom_range(1) ? $urandom_range(21000, 12000)
                                           : $urandom_range(32767));
      w.k_high_in = K_W'($urandom_range(1) ? $urandom_range(21000, 12000)
                                           : $urandom_range(32767));
      if ($urandom_range(9) == 0) w.temperature = TEMP_W'($urandom_range(4095));
      else                        w.temperature = TEMP_W'($urandom_range(1920) - 320);
      // aim most calibrations into a window and many measurements near the range switch
      if (w.op == OP_CALIBRATE && $urandom_range(9) != 0)
         w.voltage_mv = mv_for_raw($urandom_range(1) ? $urandom_range(1899, 901)
                                                     : $urandom_range(16799, 9001));
      else if (w.op == OP_MEASURE && $urandom_range(1))
         w.voltage_mv = mv_for_raw($urandom_range(4000, 1200));
      else if ($urandom_range(9) == 0)
         w.voltage_mv = MV_W'($urandom_range(8191));
      else
         w.voltage_mv = MV_W'($urandom_range(5000));
      return w;
   endfunction

   task automatic send_word(input reading_req_type w);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid       <= 1'b1;
      req_chan.op          <= w.op;
      req_chan.voltage_mv  <= w.voltage_mv;
      req_chan.temperature <= w.temperature;
      req_chan.k_low_in    <= w.k_low_in;
      req_chan.k_high_in   <= w.k_high_in;
      do @(posedge clock); while (!req_chan.ready);
      expected_readings.push_back(compensate_word(w));
      words_sent++;
   endtask

   // Hold the sender until every outstanding word has come back
   task automatic wait_drained();
      req_chan.valid <= 1'b0;
      do @(posedge clock); while (expected_readings.size() != 0);
   endtask

   task automatic write_scale(input logic [USCM_W-1:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      scale_q16 = value;
      scale_writes++;
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   task automatic check_field(input string name, input int unsigned exp, input int unsigned act);
      if (exp != act) begin
         $error("%s: expected %0d, got %0d", name, exp, act);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      reading_rsp_type exp;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (expected_readings.size() == 0) begin
            $error("result word with nothing outstanding");
            mismatches++;
         end else begin
            exp = expected_readings.pop_front();
            check_field("conductivity", 32'(exp.conductivity), 32'(rsp_chan.conductivity));
            check_field("status", 32'(exp.status), 32'(rsp_chan.status));
            check_field("high_range", 32'(exp.high_range), 32'(rsp_chan.high_range));
            check_field("k_low_out", 32'(exp.k_low_out), 32'(rsp_chan.k_low_out));
            check_field("k_high_out", 32'(exp.k_high_out), 32'(rsp_chan.k_high_out));
            words_checked++;
         end
      end
   end

   task automatic test_directed_cases();
      send_word(word(OP_MEASURE, 0, 400, 0, 0));
      send_word(word(OP_MEASURE, 5000, 400, 0, 0));
      send_word(word(OP_MEASURE, 8191, -320, 32767, 32767));
      send_word(word(OP_MEASURE, 300, 400, 0, 0));
      send_word(word(OP_MEASURE, 370, 1600, 0, 0));
      send_word(word(OP_MEASURE, 500, -465, 0, 0));
      send_word(word(OP_MEASURE, 500, -464, 0, 0));
      send_word(word(OP_MEASURE, 4000, -2048, 0, 0));
      send_word(word(OP_MEASURE, 4000, 2047, 0, 0));
      send_word(word(OP_CALIBRATE, 232, 400, 0, 0));
      send_word(word(OP_CALIBRATE, 2112, 400, 0, 0));
      send_word(word(OP_CALIBRATE, 100, 400, 0, 0));
      send_word(word(OP_CALIBRATE, 232, -465, 0, 0));
      send_word(word(OP_CALIBRATE, 148, 1600, 0, 0));
      send_word(word(OP_CALIBRATE, 2112, -320, 0, 0));
      send_word(word(OP_LOAD, 0, 0, 0, 32767));
      send_word(word(OP_MEASURE, 3000, 400, 0, 0));
      send_word(word(OP_MEASURE, 370, 400, 0, 0));
      send_word(word(OP_MEASURE, 100, 400, 0, 0));
      send_word(word(OP_LOAD, 8191, 2047, 32767, 0));
      send_word(word(OP_UNUSED, 8191, -1, 32767, 32767));
      send_word(word(OP_LOAD, 0, 0, K_ONE, K_ONE));
      send_word(word(OP_MEASURE, 2000, 400, 0, 0));
      wait_drained();
   endtask

   task automatic test_scale_extremes();
      logic [USCM_W-1:0] scales [5];
      scales = '{24'd0, 24'hFFFFFF, 24'd1, USCM_W'($urandom_range(24'hFFFFFF)), USCM_RESET};
      foreach (scales[i]) begin
         write_scale(scales[i]);
         send_word(word(OP_MEASURE, 8191, 400, 0, 0));
         send_word(word(OP_CALIBRATE, 4096, 400, 0, 0));
         repeat (40) send_word(random_word());
         wait_drained();
      end
   endtask

   task automatic run_phase(input int idle_pct, input int stall_pct, input int count);
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      repeat (count) send_word(random_word());
      wait_drained();
   endtask

   task automatic test_random_traffic();
      run_phase(0, 0, 500);
      run_phase(67, 0, 500);
      run_phase(0, 67, 500);
      run_phase(28, 28, 500);
   endtask

   initial begin
      reset                <= 1'b1;
      csr_wr_en            <= 1'b0;
      csr_wr_data          <= '0;
      req_chan.valid       <= 1'b0;
      req_chan.op          <= OP_MEASURE;
      req_chan.voltage_mv  <= '0;
      req_chan.temperature <= '0;
      req_chan.k_low_in    <= '0;
      req_chan.k_high_in   <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      test_directed_cases();
      test_scale_extremes();
      test_random_traffic();

      wait_drained();
      repeat (48) @(posedge clock);
      $display("tb: %0d words sent, %0d results checked, %0d scale writes,", words_sent,
               words_checked, scale_writes);
      $display("tb: four sender/receiver idle mixes, %0d mismatches", mismatches);
      if (mismatches == 0 && expected_readings.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
